### rtl/rtcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtcp_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    KIND_SR   = 3'd0,
    KIND_LAST = 3'd1,
    KIND_RRTR = 3'd2,
    KIND_ACK  = 3'd3,
    KIND_LOST = 3'd4,
    KIND_DONE = 3'd5
  } kind_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_VER   = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam logic [7:0] CFG_LOCAL_ID  = 8'd0;
  localparam logic [7:0] CFG_REMOTE_ID = 8'd1;
  localparam logic [7:0] CFG_APP_NAME  = 8'd2;
  localparam logic [7:0] CFG_ALL_LOST  = 8'd3;

  localparam logic [15:0] ALL_LOST_RESET = 16'hffff;

  // everything one byte leaves for the output side
  typedef struct packed {
    logic             has_main;
    kind_t            main_kind;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    logic [WordW-1:0] e;
    logic [7:0]       lost_mask;
    logic [15:0]      lost_pid;
    logic [WordW-1:0] lost_frame;
    logic             has_done;
    logic [1:0]       status;
  } job_t;

endpackage
`default_nettype wire

### rtl/rtcp_compound_packet_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | content
// s_*     | in        | one packet byte per beat, tlast on the final byte
// m_*     | out       | one record per beat, tuser kind, tlast on the last record of a byte
// cfg_*   | in        | register index and 32-bit write data
//
// a byte is taken every cycle unless records from the previous byte are still queued;
// one byte gives at most a record plus up to eight lost ids plus packet done, one per cycle while m_tready is high
// a record reaches m_tvalid after its byte via the job register and then the output register
// while the output register stalls with records queued, s_tready stays low for every byte
// rst is synchronous and clears parse state, the config registers and the job and output valid flags
module rtcp_compound_packet_parser
  import rtcp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,    // packet_byte
  input  wire logic         s_tlast,    // final_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,    // parse_status, word_a, word_b, word_c, word_d, word_e
  output logic [2:0]        m_tuser,    // record_kind
  output logic              m_tlast,    // run_end
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [31:0] local_source_id;
  logic [31:0] remote_source_id;
  logic [31:0] app_feedback_name;
  logic [15:0] all_lost_marker;
  logic        job_load;
  logic        job_free;
  job_t        job;

  assign cfg_ready = 1'b1;
  assign s_tready  = job_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_source_id   <= '0;
      remote_source_id  <= '0;
      app_feedback_name <= '0;
      all_lost_marker   <= ALL_LOST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOCAL_ID:  local_source_id   <= cfg_data;
        CFG_REMOTE_ID: remote_source_id  <= cfg_data;
        CFG_APP_NAME:  app_feedback_name <= cfg_data;
        CFG_ALL_LOST:  all_lost_marker   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rtcp_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (s_tvalid && s_tready),
    .packet_byte       (s_tdata),
    .final_byte        (s_tlast),
    .local_source_id   (local_source_id),
    .remote_source_id  (remote_source_id),
    .app_feedback_name (app_feedback_name),
    .all_lost_marker   (all_lost_marker),
    .job_load          (job_load),
    .job               (job)
  );

  rtcp_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .job_load (job_load),
    .job_in   (job),
    .job_free (job_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### rtl/rtcp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module rtcp_parser
  import rtcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        final_byte,
  input  wire logic [31:0] local_source_id,
  input  wire logic [31:0] remote_source_id,
  input  wire logic [31:0] app_feedback_name,
  input  wire logic [15:0] all_lost_marker,
  output logic             job_load,
  output job_t             job
);

  typedef enum logic [3:0] {
    PH_HDR, PH_SKIP, PH_SSRC, PH_SR_INFO, PH_RB, PH_FB_IDS, PH_FB_NAME,
    PH_FB_ACK, PH_FB_LOST, PH_XR_BLK, PH_XR_RRTR, PH_XR_SKIP
  } phase_t;

  function automatic logic [4:0] rec_len(phase_t ph);
    case (ph)
      PH_SR_INFO: rec_len = 5'd20;
      PH_RB:      rec_len = 5'd24;
      PH_FB_IDS, PH_FB_ACK, PH_FB_LOST, PH_XR_RRTR: rec_len = 5'd8;
      default:    rec_len = 5'd4;
    endcase
  endfunction

  phase_t      phase, phase_next;
  logic [17:0] sub_left, sub_left_next;
  logic [17:0] field_left, field_left_next;
  logic [7:0]  ptype, ptype_next;
  logic [4:0]  icount, icount_next;
  logic [7:0]  loop_cnt, loop_cnt_next;
  logic [31:0] shift, shift_next;
  logic [31:0] held [5];
  logic [31:0] held_next [5];
  logic [1:0]  err, err_next;

  always_comb begin
    logic [4:0]  total;
    logic [4:0]  idx;
    logic [31:0] w;
    logic        fin_rec;
    phase_next      = phase;
    sub_left_next   = sub_left;
    field_left_next = field_left;
    ptype_next      = ptype;
    icount_next     = icount;
    loop_cnt_next   = loop_cnt;
    shift_next      = shift;
    for (int i = 0; i < 5; i++) held_next[i] = held[i];
    err_next        = err;
    job             = '0;
    total           = 5'd4;
    idx             = '0;
    w               = '0;
    fin_rec         = 1'b0;

    if (err == STATUS_OK) begin
      if (phase == PH_HDR) begin
        shift_next = {shift[23:0], packet_byte};
        if (field_left == '0 && packet_byte[7:6] != 2'd2) begin
          err_next = STATUS_BAD_VER;
        end else begin
          if (field_left == '0) icount_next = packet_byte[4:0];
          field_left_next = field_left + 18'd1;
          if (field_left_next >= 18'd4) begin
            ptype_next    = shift_next[23:16];
            sub_left_next = {shift_next[15:0], 2'b00};
            if (ptype_next == 8'd200 || ptype_next == 8'd201 || ptype_next == 8'd207)
              phase_next = PH_SSRC;
            else if (ptype_next == 8'd206 && icount_next == 5'd15)
              phase_next = PH_FB_IDS;
            else
              phase_next = PH_SKIP;
            field_left_next = (phase_next == PH_SKIP) ? 18'd0 : {13'd0, rec_len(phase_next)};
            shift_next = '0;
            if (sub_left_next == '0) begin
              if (phase_next == PH_SKIP) begin
                phase_next = PH_HDR;
                field_left_next = '0;
              end else begin
                err_next = STATUS_TRUNCATED;
              end
            end
          end
        end
      end else begin
        sub_left_next = sub_left - 18'd1;
        if (phase == PH_XR_SKIP) begin
          if (field_left != '0) field_left_next = field_left - 18'd1;
          if (field_left_next == '0) begin
            phase_next = PH_XR_BLK;
            field_left_next = 18'd4;
            shift_next = '0;
          end
        end else if (phase != PH_SKIP) begin
          total = rec_len(phase);
          shift_next = {shift[23:0], packet_byte};
          if (field_left != '0) field_left_next = field_left - 18'd1;
          if (field_left_next[1:0] == 2'b00 && field_left_next < {13'd0, total}) begin
            idx = ((total - field_left_next[4:0]) >> 2) - 5'd1;
            if (idx < 5'd5) held_next[idx[2:0]] = shift_next;
            fin_rec = (field_left_next == '0);
          end
        end
        if (fin_rec) begin
          w = shift_next;
          case (phase)
            PH_SSRC: begin
              if (w != remote_source_id) phase_next = PH_SKIP;
              else if (ptype == 8'd200) phase_next = PH_SR_INFO;
              else if (ptype == 8'd201) phase_next = (icount != '0) ? PH_RB : PH_SKIP;
              else phase_next = PH_XR_BLK;
            end
            PH_SR_INFO: begin
              job.has_main = 1'b1;
              job.main_kind = KIND_SR;
              job.a = held_next[0];
              job.b = held_next[1];
              job.c = held_next[2];
              job.d = held_next[3];
              job.e = w;
              phase_next = (icount != '0) ? PH_RB : PH_SKIP;
            end
            PH_RB: begin
              if (held_next[0] == local_source_id) begin
                job.has_main = 1'b1;
                job.main_kind = KIND_LAST;
                job.a = held_next[4];
                job.b = w;
              end
              icount_next = icount - 5'd1;
              phase_next = (icount_next != '0) ? PH_RB : PH_SKIP;
            end
            PH_FB_IDS:  phase_next = (held_next[0] == remote_source_id) ? PH_FB_NAME : PH_SKIP;
            PH_FB_NAME: phase_next = (w == app_feedback_name) ? PH_FB_ACK : PH_SKIP;
            PH_FB_ACK: begin
              job.has_main = 1'b1;
              job.main_kind = KIND_ACK;
              job.a = held_next[0];
              job.b = {16'd0, w[15:0]};
              job.c = remote_source_id;
              loop_cnt_next = w[31:24];
              phase_next = (loop_cnt_next != '0) ? PH_FB_LOST : PH_SKIP;
            end
            PH_FB_LOST: begin
              job.has_main = 1'b1;
              job.main_kind = KIND_LOST;
              job.a = held_next[0];
              job.b = {16'd0, w[31:16]};
              job.lost_pid = w[31:16];
              job.lost_frame = held_next[0];
              job.lost_mask = (w[31:16] != all_lost_marker) ? w[15:8] : 8'd0;
              loop_cnt_next = loop_cnt - 8'd1;
              phase_next = (loop_cnt_next != '0) ? PH_FB_LOST : PH_SKIP;
            end
            PH_XR_BLK: begin
              if (w[31:24] == 8'd4) begin
                if (w[15:0] != 16'd2) err_next = STATUS_TRUNCATED;
                else phase_next = PH_XR_RRTR;
              end else if (w[15:0] == 16'd0) begin
                phase_next = PH_XR_BLK;
              end else begin
                phase_next = PH_XR_SKIP;
              end
            end
            PH_XR_RRTR: begin
              job.has_main = 1'b1;
              job.main_kind = KIND_RRTR;
              job.a = held_next[0];
              job.b = w;
              phase_next = PH_XR_BLK;
            end
            default: phase_next = PH_SKIP;
          endcase
          if (err_next == STATUS_OK) begin
            field_left_next = (phase_next == PH_SKIP) ? 18'd0 : {13'd0, rec_len(phase_next)};
            if (phase_next == PH_XR_SKIP) field_left_next = {w[15:0], 2'b00};
            shift_next = '0;
          end
        end
        if (err_next == STATUS_OK && sub_left_next == '0) begin
          if (phase_next == PH_SKIP || (phase_next == PH_XR_BLK && field_left_next == 18'd4)) begin
            phase_next = PH_HDR;
            field_left_next = '0;
            shift_next = '0;
          end else begin
            err_next = STATUS_TRUNCATED;
          end
        end
      end
    end

    if (final_byte) begin
      if (err_next == STATUS_OK && !(phase_next == PH_HDR && field_left_next == '0))
        err_next = STATUS_TRUNCATED;
      job.has_done = 1'b1;
      job.status = err_next;
      phase_next      = PH_HDR;
      field_left_next = '0;
      shift_next      = '0;
      sub_left_next   = '0;
      ptype_next      = '0;
      icount_next     = '0;
      loop_cnt_next   = '0;
      for (int i = 0; i < 5; i++) held_next[i] = '0;
      err_next        = STATUS_OK;
    end
  end

  assign job_load = accept && (job.has_main || job.has_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR;
      sub_left   <= '0;
      field_left <= '0;
      ptype      <= '0;
      icount     <= '0;
      loop_cnt   <= '0;
      shift      <= '0;
      for (int i = 0; i < 5; i++) held[i] <= '0;
      err        <= STATUS_OK;
    end else if (accept) begin
      phase      <= phase_next;
      sub_left   <= sub_left_next;
      field_left <= field_left_next;
      ptype      <= ptype_next;
      icount     <= icount_next;
      loop_cnt   <= loop_cnt_next;
      shift      <= shift_next;
      for (int i = 0; i < 5; i++) held[i] <= held_next[i];
      err        <= err_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rtcp_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
module rtcp_emitter
  import rtcp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         job_load,
  input  job_t              job_in,
  output logic              job_free,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,  // parse_status, word_a..word_e, zero pad
  output logic [2:0]        m_tuser,  // record_kind
  output logic              m_tlast   // run_end
);

  job_t        job;
  logic        job_valid;
  logic        out_free;
  logic        can_emit;
  logic        last;
  logic [2:0]  low_idx;
  logic [7:0]  mask_left;
  kind_t       kind_sel;
  logic [1:0]  status_sel;
  logic [31:0] a_sel, b_sel, c_sel, d_sel, e_sel;

  always_comb begin
    low_idx = '0;
    for (int i = 7; i >= 0; i--) if (job.lost_mask[i]) low_idx = 3'(i);
  end

  always_comb begin
    mask_left  = job.lost_mask;
    kind_sel   = KIND_DONE;
    status_sel = STATUS_OK;
    a_sel = '0; b_sel = '0; c_sel = '0; d_sel = '0; e_sel = '0;
    if (job.has_main) begin
      kind_sel = job.main_kind;
      a_sel = job.a; b_sel = job.b; c_sel = job.c; d_sel = job.d; e_sel = job.e;
    end else if (job.lost_mask != '0) begin
      kind_sel = KIND_LOST;
      a_sel = job.lost_frame;
      b_sel = {16'd0, job.lost_pid + {13'd0, low_idx} + 16'd1};
      mask_left[low_idx] = 1'b0;
    end else begin
      status_sel = job.status;
    end
    last = job.has_main ? (job.lost_mask == '0 && !job.has_done)
                        : (job.lost_mask != '0 ? (mask_left == '0 && !job.has_done) : 1'b1);
  end

  assign out_free = !m_tvalid || m_tready;
  assign can_emit = job_valid && out_free;
  assign job_free = !job_valid || (can_emit && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (can_emit) begin
        m_tvalid <= 1'b1;
        m_tuser  <= kind_sel;
        m_tlast  <= last;
        m_tdata  <= {6'd0, e_sel, d_sel, c_sel, b_sel, a_sel, status_sel};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (job_load) begin
        job_valid <= 1'b1;
        job       <= job_in;
      end else if (can_emit) begin
        if (last) job_valid <= 1'b0;
        if (job.has_main) job.has_main <= 1'b0;
        else job.lost_mask <= mask_left;
      end
    end
  end

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DONE |-> m_tlast)
    else $error("packet done beat without run end");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_DONE |-> m_tdata[1:0] == STATUS_OK)
    else $error("status on a non-done beat");

  a_job_has_work: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job.has_main || job.lost_mask != '0 || job.has_done)
    else $error("pending job with nothing to send");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    job_load |-> job_free)
    else $error("job loaded while previous one still pending");

endmodule
`default_nettype wire

### bench/rtcp_compound_packet_parser_test.sv
`timescale 1ns / 1ps
module rtcp_compound_packet_parser_test;
  import rtcp_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = 8'd0;
  logic [31:0]  cfg_data = 32'd0;

  rtcp_compound_packet_parser u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    kind_t       kind;
    logic [1:0]  status;
    logic [31:0] a, b, c, d, e;
    logic        run_end;
  } record_t;

  typedef enum logic [3:0] {
    P_HDR, P_SKIP, P_SSRC, P_SR, P_RB, P_FB_IDS, P_FB_NAME, P_FB_ACK, P_FB_LOST,
    P_XR_BLK, P_XR_RRTR, P_XR_SKIP
  } phase_t;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [1:0] status;
  } row_t;

  // register copies
  logic [31:0] local_id, remote_id, app_name;
  logic [15:0] lost_marker;

  // parser state copy
  phase_t      ph;
  logic [17:0] sub_left, fld_left;
  logic [7:0]  ptype;
  logic [4:0]  icount;
  logic [7:0]  lcount;
  logic [31:0] shreg;
  logic [31:0] held [5];
  logic [1:0]  err;

  record_t byte_records[$];
  record_t pending_records[$];
  logic [7:0] pkt[$];

  int errors = 0;
  int hold_len = 0;
  bit no_gaps = 0;

  function automatic logic [17:0] rec_bytes(phase_t p);
    case (p)
      P_SR: return 18'd20;
      P_RB: return 18'd24;
      P_FB_IDS, P_FB_ACK, P_FB_LOST, P_XR_RRTR: return 18'd8;
      default: return 18'd4;
    endcase
  endfunction

  function automatic void enter_phase(phase_t p);
    ph = p;
    fld_left = (p == P_HDR || p == P_SKIP) ? 18'd0 : rec_bytes(p);
    shreg = 32'd0;
  endfunction

  function automatic void clear_state();
    enter_phase(P_HDR);
    sub_left = 0;
    ptype = 0;
    icount = 0;
    lcount = 0;
    for (int i = 0; i < 5; i++) held[i] = 32'd0;
    err = 0;
  endfunction

  function automatic void add_rec(kind_t k, logic [1:0] st, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic [31:0] d, logic [31:0] e);
    record_t r;
    if (byte_records.size() >= 10) return;
    r.kind = k; r.status = st; r.a = a; r.b = b; r.c = c; r.d = d; r.e = e;
    r.run_end = 1'b0;
    byte_records.push_back(r);
  endfunction

  function automatic void close_chunk();
    if (ph == P_SKIP || (ph == P_XR_BLK && fld_left == 18'd4)) enter_phase(P_HDR);
    else err = STATUS_TRUNCATED;
  endfunction

  function automatic void end_record();
    logic [31:0] w;
    logic [15:0] pid;
    logic [7:0]  mask;
    w = shreg;
    case (ph)
      P_SSRC: begin
        if (w != remote_id) enter_phase(P_SKIP);
        else if (ptype == 8'd200) enter_phase(P_SR);
        else if (ptype == 8'd201) enter_phase(icount != 0 ? P_RB : P_SKIP);
        else enter_phase(P_XR_BLK);
      end
      P_SR: begin
        add_rec(KIND_SR, STATUS_OK, held[0], held[1], held[2], held[3], w);
        enter_phase(icount != 0 ? P_RB : P_SKIP);
      end
      P_RB: begin
        if (held[0] == local_id) add_rec(KIND_LAST, STATUS_OK, held[4], w, 0, 0, 0);
        icount = icount - 5'd1;
        enter_phase(icount != 0 ? P_RB : P_SKIP);
      end
      P_FB_IDS: enter_phase(held[0] == remote_id ? P_FB_NAME : P_SKIP);
      P_FB_NAME: enter_phase(w == app_name ? P_FB_ACK : P_SKIP);
      P_FB_ACK: begin
        add_rec(KIND_ACK, STATUS_OK, held[0], {16'd0, w[15:0]}, remote_id, 0, 0);
        lcount = w[31:24];
        enter_phase(lcount != 0 ? P_FB_LOST : P_SKIP);
      end
      P_FB_LOST: begin
        pid = w[31:16];
        mask = w[15:8];
        add_rec(KIND_LOST, STATUS_OK, held[0], {16'd0, pid}, 0, 0, 0);
        if (pid != lost_marker) begin
          for (int i = 0; i < 8; i++) begin
            pid = pid + 16'd1;
            if (mask[i]) add_rec(KIND_LOST, STATUS_OK, held[0], {16'd0, pid}, 0, 0, 0);
          end
        end
        lcount = lcount - 8'd1;
        enter_phase(lcount != 0 ? P_FB_LOST : P_SKIP);
      end
      P_XR_BLK: begin
        if (w[31:24] == 8'd4) begin
          if (w[15:0] != 16'd2) err = STATUS_TRUNCATED;
          else enter_phase(P_XR_RRTR);
        end else if (w[15:0] == 16'd0) begin
          enter_phase(P_XR_BLK);
        end else begin
          enter_phase(P_XR_SKIP);
          fld_left = {w[15:0], 2'b00};
        end
      end
      P_XR_RRTR: begin
        add_rec(KIND_RRTR, STATUS_OK, held[0], w, 0, 0, 0);
        enter_phase(P_XR_BLK);
      end
      default: enter_phase(P_SKIP);
    endcase
  endfunction

  function automatic void take_header(logic [7:0] b);
    shreg = {shreg[23:0], b};
    if (fld_left == 0) begin
      if (b[7:6] != 2'd2) begin
        err = STATUS_BAD_VER;
        return;
      end
      icount = b[4:0];
    end
    fld_left = fld_left + 18'd1;
    if (fld_left < 4) return;
    ptype = shreg[23:16];
    sub_left = {shreg[15:0], 2'b00};
    if (ptype == 8'd200 || ptype == 8'd201 || ptype == 8'd207) enter_phase(P_SSRC);
    else if (ptype == 8'd206 && icount == 5'd15) enter_phase(P_FB_IDS);
    else enter_phase(P_SKIP);
    if (sub_left == 0) close_chunk();
  endfunction

  function automatic void take_chunk(logic [7:0] b);
    logic [17:0] total, idx;
    sub_left = sub_left - 18'd1;
    if (ph == P_XR_SKIP) begin
      if (fld_left != 0) fld_left = fld_left - 18'd1;
      if (fld_left == 0) enter_phase(P_XR_BLK);
    end else if (ph != P_SKIP) begin
      total = rec_bytes(ph);
      shreg = {shreg[23:0], b};
      if (fld_left != 0) fld_left = fld_left - 18'd1;
      if (fld_left[1:0] == 2'd0 && fld_left < total) begin
        idx = (total - fld_left) / 4 - 1;
        if (idx < 5) held[idx] = shreg;
        if (fld_left == 0) end_record();
      end
    end
    if (err == 0 && sub_left == 0) close_chunk();
  endfunction

  // fills byte_records with what one accepted byte should produce
  function automatic void parse_byte(logic [7:0] b, logic fin);
    byte_records.delete();
    if (err == 0) begin
      if (ph == P_HDR) take_header(b);
      else take_chunk(b);
    end
    if (fin) begin
      if (err == 0 && !(ph == P_HDR && fld_left == 0)) err = STATUS_TRUNCATED;
      add_rec(KIND_DONE, err, 0, 0, 0, 0, 0);
      clear_state();
    end
    if (byte_records.size() > 0) byte_records[byte_records.size()-1].run_end = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin, logic typed, logic [1:0] st);
    int gap, r;
    bit rdy;
    record_t t;
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 60 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 30)));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    parse_byte(b, fin);
    if (typed) begin
      // short rows: the packet-done status is known by inspection
      t = '{KIND_DONE, st, 0, 0, 0, 0, 0, 1'b1};
      byte_records.delete();
      byte_records.push_back(t);
    end
    foreach (byte_records[i]) pending_records.push_back(byte_records[i]);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOCAL_ID: local_id = data;
      CFG_REMOTE_ID: remote_id = data;
      CFG_APP_NAME: app_name = data;
      CFG_ALL_LOST: lost_marker = data[15:0];
      default: ;
    endcase
  endtask

  function automatic void put32(logic [31:0] w);
    for (int i = 3; i >= 0; i--) pkt.push_back(w[8*i +: 8]);
  endfunction

  function automatic logic [31:0] pick(logic [31:0] good, int pct);
    return ($urandom_range(0, 99) < pct) ? good : $urandom;
  endfunction

  function automatic void put_header(logic [4:0] ic, logic [7:0] pt, int words);
    pkt.push_back({2'b10, 1'($urandom_range(0, 1)), ic});
    pkt.push_back(pt);
    pkt.push_back(8'(words >> 8));
    pkt.push_back(8'(words));
  endfunction

  // one sub-packet with random content, mostly well formed
  function automatic void build_sub();
    int sel, ic, n, tail, words;
    logic [31:0] body[$];
    logic [15:0] len;
    sel = $urandom_range(0, 99);
    tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    if (sel < 20 || (sel >= 20 && sel < 32)) begin
      ic = $urandom_range(0, 2);
      body.push_back(pick(remote_id, 85));
      if (sel < 20) for (int i = 0; i < 5; i++) body.push_back($urandom);
      for (int k = 0; k < ic; k++) begin
        body.push_back(pick(local_id, 60));
        for (int i = 0; i < 5; i++) body.push_back($urandom);
      end
      for (int i = 0; i < tail; i++) body.push_back($urandom);
      put_header(5'(ic), sel < 20 ? 8'd200 : 8'd201, body.size());
    end else if (sel < 62) begin
      n = $urandom_range(0, 3);
      body.push_back(pick(remote_id, 90));
      body.push_back($urandom);
      body.push_back(pick(app_name, 90));
      body.push_back($urandom);
      body.push_back({8'(n), 8'($urandom), 16'($urandom)});
      for (int k = 0; k < n; k++)
        body.push_back({($urandom_range(0, 4) == 0) ? lost_marker : 16'($urandom),
                        16'($urandom)});
      for (int i = 0; i < tail; i++) body.push_back($urandom);
      put_header(($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'd15, 8'd206, body.size());
    end else if (sel < 82) begin
      body.push_back(pick(remote_id, 85));
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            body.push_back({8'd4, 8'($urandom), 16'd2});
            body.push_back($urandom);
            body.push_back($urandom);
          end
          3: body.push_back({8'd4, 8'($urandom), 16'($urandom_range(0, 3))});
          default: begin
            len = $urandom_range(0, 2);
            body.push_back({8'($urandom_range(0, 255) | 8'h01) ^ 8'h04 ^ 8'h04,
                            8'($urandom), len});
            for (int i = 0; i < len; i++) body.push_back($urandom);
          end
        endcase
      end
      put_header(5'($urandom), 8'd207, body.size());
    end else if (sel < 92) begin
      words = $urandom_range(0, 3);
      for (int i = 0; i < words; i++) body.push_back($urandom);
      put_header(5'($urandom), ($urandom_range(0, 1) == 1) ? 8'd205 : 8'($urandom),
                 body.size());
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
      return;
    end
    foreach (body[i]) put32(body[i]);
  endfunction

  task automatic send_compound();
    int subs, cut;
    pkt.delete();
    subs = $urandom_range(1, 3);
    for (int i = 0; i < subs; i++) build_sub();
    if ($urandom_range(0, 9) == 0 && pkt.size() > 1) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    if ($urandom_range(0, 19) == 0) pkt[0] = pkt[0] ^ 8'hc0;
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, STATUS_OK);
    no_gaps = 0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    wait (pending_records.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  row_t rows[16] = '{
    '{8'h40, 1'b1, 1'b1, STATUS_BAD_VER},
    '{8'hff, 1'b1, 1'b1, STATUS_BAD_VER},
    '{8'h00, 1'b1, 1'b1, STATUS_BAD_VER},
    '{8'h80, 1'b1, 1'b1, STATUS_TRUNCATED},
    '{8'h80, 1'b0, 1'b0, STATUS_OK},
    '{8'hcd, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, STATUS_OK},
    '{8'h80, 1'b0, 1'b0, STATUS_OK},
    '{8'hc9, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h01, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, STATUS_OK}
  };

  initial begin
    int sent;
    local_id = 0; remote_id = 0; app_name = 0; lost_marker = ALL_LOST_RESET;
    clear_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_byte(rows[i].b, rows[i].fin, rows[i].typed, rows[i].status);
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_LOCAL_ID, 32'd0); write_reg(CFG_REMOTE_ID, 32'd0);
          write_reg(CFG_APP_NAME, 32'd0); write_reg(CFG_ALL_LOST, 32'd0);
        end
        1: begin
          write_reg(CFG_LOCAL_ID, 32'hffff_ffff); write_reg(CFG_REMOTE_ID, 32'hffff_ffff);
          write_reg(CFG_APP_NAME, 32'hffff_ffff); write_reg(CFG_ALL_LOST, 32'h0000_ffff);
        end
        default: begin
          write_reg(CFG_LOCAL_ID, $urandom); write_reg(CFG_REMOTE_ID, $urandom);
          write_reg(CFG_APP_NAME, $urandom); write_reg(CFG_ALL_LOST, $urandom);
        end
      endcase
      // index outside the register map must change nothing
      write_reg(8'hff, $urandom);
      // long output stall while bytes keep coming
      if (phase == 2) hold_len = 400;
      sent = 0;
      while (sent < 55) begin
        send_compound();
        sent += pkt.size();
      end
      drain();
    end
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int n, r, g;
    wait (!rst);
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        n = ($urandom_range(0, 19) == 0) ? 100 : $urandom_range(1, 12);
        m_tready <= 1'b1;
        repeat (n) @(posedge clk);
        r = $urandom_range(0, 99);
        g = r < 50 ? 0 : (r < 85 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // inputs only move at rising edges, so the falling edge shows the beat taken next
  always @(negedge clk) begin
    record_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_records.size() == 0) begin
        $error("record_kind: expected none, got %0d", m_tuser);
        errors++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 32'(want.kind), 32'(m_tuser));
        check_field("parse_status", 32'(want.status), 32'(m_tdata[1:0]));
        check_field("word_a", want.a, m_tdata[33:2]);
        check_field("word_b", want.b, m_tdata[65:34]);
        check_field("word_c", want.c, m_tdata[97:66]);
        check_field("word_d", want.d, m_tdata[129:98]);
        check_field("word_e", want.e, m_tdata[161:130]);
        check_field("run_end", 32'(want.run_end), 32'(m_tlast));
      end
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
